// ----- rtl/sit_pkg.sv -----
package sit_pkg;

  localparam int COORD_BITS = 16;
  localparam int TOL_BITS   = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int CMP_W      = ((SUM_W > TOL_BITS + 1) ? SUM_W : TOL_BITS + 1) + 1;
  localparam int NUM_TESTS  = 4;

  localparam int TEST_SEG2_START = 0;
  localparam int TEST_SEG2_END   = 1;
  localparam int TEST_SEG1_START = 2;
  localparam int TEST_SEG1_END   = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [CMP_W-1:0]      cmp_t;
  typedef logic signed [2:0]            code_t;
  typedef logic [TOL_BITS-1:0]          tol_t;

  localparam code_t ORIENT_ON     = 3'sd0;
  localparam code_t ORIENT_CCW    = 3'sd1;
  localparam code_t ORIENT_CW     = -3'sd1;
  localparam code_t ORIENT_BEHIND = 3'sd2;
  localparam code_t ORIENT_BEYOND = -3'sd2;

  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t qx;
    diff_t qy;
  } orient_diff_t;

  typedef orient_diff_t [NUM_TESTS-1:0] diff_set_t;

  // Direction of the segment and offset of the point, both from the segment start.
  function automatic orient_diff_t make_diff(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                             coord_t px, coord_t py);
    orient_diff_t d;
    d.dx = DIFF_W'(ex) - DIFF_W'(sx);
    d.dy = DIFF_W'(ey) - DIFF_W'(sy);
    d.qx = DIFF_W'(px) - DIFF_W'(sx);
    d.qy = DIFF_W'(py) - DIFF_W'(sy);
    return d;
  endfunction

  // True when the product of two orientation codes is zero or negative.
  function automatic logic codes_straddle(code_t a, code_t b);
    return (a == ORIENT_ON) || (b == ORIENT_ON) || (a[2] != b[2]);
  endfunction

endpackage

// ----- rtl/sit_if.sv -----
interface sit_req_if;
  import sit_pkg::*;

  logic   valid;
  logic   ready;
  coord_t seg1_start_x;
  coord_t seg1_start_y;
  coord_t seg1_end_x;
  coord_t seg1_end_y;
  coord_t seg2_start_x;
  coord_t seg2_start_y;
  coord_t seg2_end_x;
  coord_t seg2_end_y;

  modport source (
    output valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
           seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
    input  ready
  );

  modport sink (
    input  valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
           seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
    output ready
  );
endinterface

interface sit_rsp_if;
  import sit_pkg::*;

  logic  valid;
  logic  ready;
  logic  intersects;
  code_t orient_seg2_start;
  code_t orient_seg2_end;
  code_t orient_seg1_start;
  code_t orient_seg1_end;

  modport source (
    output valid, intersects, orient_seg2_start, orient_seg2_end,
           orient_seg1_start, orient_seg1_end,
    input  ready
  );

  modport sink (
    input  valid, intersects, orient_seg2_start, orient_seg2_end,
           orient_seg1_start, orient_seg1_end,
    output ready
  );
endinterface

// ----- rtl/sit_front.sv -----
module sit_front (
  input  logic               clk,
  input  logic               rst,
  sit_req_if.sink            request,
  output logic               push_valid,
  input  logic               push_ready,
  output sit_pkg::diff_set_t push_data
);
  import sit_pkg::*;

  logic      hold_valid;
  diff_set_t hold_data;
  logic      load;

  assign request.ready = !hold_valid || push_ready;
  assign load          = request.valid && request.ready;
  assign push_valid    = hold_valid;
  assign push_data     = hold_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (request.ready) begin
      hold_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_data[TEST_SEG2_START] <= make_diff(request.seg1_start_x, request.seg1_start_y,
                                              request.seg1_end_x, request.seg1_end_y,
                                              request.seg2_start_x, request.seg2_start_y);
      hold_data[TEST_SEG2_END]   <= make_diff(request.seg1_start_x, request.seg1_start_y,
                                              request.seg1_end_x, request.seg1_end_y,
                                              request.seg2_end_x, request.seg2_end_y);
      hold_data[TEST_SEG1_START] <= make_diff(request.seg2_start_x, request.seg2_start_y,
                                              request.seg2_end_x, request.seg2_end_y,
                                              request.seg1_start_x, request.seg1_start_y);
      hold_data[TEST_SEG1_END]   <= make_diff(request.seg2_start_x, request.seg2_start_y,
                                              request.seg2_end_x, request.seg2_end_y,
                                              request.seg1_end_x, request.seg1_end_y);
    end
  end

endmodule

// ----- rtl/sit_queue.sv -----
module sit_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  sit_pkg::diff_set_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output sit_pkg::diff_set_t pop_data
);
  import sit_pkg::*;

  diff_set_t   entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/sit_back.sv -----
module sit_back (
  input  logic               clk,
  input  logic               rst,
  input  sit_pkg::tol_t      tolerance,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  sit_pkg::diff_set_t pop_data,
  sit_rsp_if.source          result
);
  import sit_pkg::*;

  typedef struct packed {
    prod_t dxqy;
    prod_t dyqx;
    prod_t dxqx;
    prod_t dyqy;
    prod_t dxdx;
    prod_t dydy;
    prod_t qxqx;
    prod_t qyqy;
  } prod_set_t;

  typedef struct packed {
    cmp_t cr;
    cmp_t dt;
    cmp_t qq;
    cmp_t ddt;
  } sum_set_t;

  function automatic code_t classify(sum_set_t s, cmp_t tol, cmp_t ntol);
    code_t c;
    if (s.cr > tol) begin
      c = ORIENT_CCW;
    end else if (s.cr < ntol) begin
      c = ORIENT_CW;
    end else if (s.dt < ntol) begin
      c = ORIENT_BEHIND;
    end else if (s.qq > s.ddt) begin
      c = ORIENT_BEYOND;
    end else begin
      c = ORIENT_ON;
    end
    return c;
  endfunction

  logic      v1, v2, v3;
  logic      en1, en2, en3;
  prod_set_t prods [NUM_TESTS];
  sum_set_t  sums  [NUM_TESTS];
  cmp_t      tol_s;
  cmp_t      ntol_s;
  code_t     codes [NUM_TESTS];

  assign en3       = !v3 || result.ready;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign pop_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= pop_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && pop_valid) begin
      for (int i = 0; i < NUM_TESTS; i++) begin
        prods[i].dxqy <= pop_data[i].dx * pop_data[i].qy;
        prods[i].dyqx <= pop_data[i].dy * pop_data[i].qx;
        prods[i].dxqx <= pop_data[i].dx * pop_data[i].qx;
        prods[i].dyqy <= pop_data[i].dy * pop_data[i].qy;
        prods[i].dxdx <= pop_data[i].dx * pop_data[i].dx;
        prods[i].dydy <= pop_data[i].dy * pop_data[i].dy;
        prods[i].qxqx <= pop_data[i].qx * pop_data[i].qx;
        prods[i].qyqy <= pop_data[i].qy * pop_data[i].qy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      tol_s  <= $signed(CMP_W'(tolerance));
      ntol_s <= -$signed(CMP_W'(tolerance));
      for (int i = 0; i < NUM_TESTS; i++) begin
        sums[i].cr  <= CMP_W'(prods[i].dxqy) - CMP_W'(prods[i].dyqx);
        sums[i].dt  <= CMP_W'(prods[i].dxqx) + CMP_W'(prods[i].dyqy);
        sums[i].qq  <= CMP_W'(prods[i].qxqx) + CMP_W'(prods[i].qyqy);
        sums[i].ddt <= CMP_W'(prods[i].dxdx) + CMP_W'(prods[i].dydy)
                       + $signed(CMP_W'(tolerance));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      for (int i = 0; i < NUM_TESTS; i++) begin
        codes[i] <= classify(sums[i], tol_s, ntol_s);
      end
    end
  end

  assign result.valid             = v3;
  assign result.orient_seg2_start = codes[TEST_SEG2_START];
  assign result.orient_seg2_end   = codes[TEST_SEG2_END];
  assign result.orient_seg1_start = codes[TEST_SEG1_START];
  assign result.orient_seg1_end   = codes[TEST_SEG1_END];
  assign result.intersects =
    codes_straddle(codes[TEST_SEG2_START], codes[TEST_SEG2_END]) &&
    codes_straddle(codes[TEST_SEG1_START], codes[TEST_SEG1_END]);

endmodule

// ----- rtl/segment_intersection_test.sv -----
// Segment intersection test. Each request on the request channel carries two
// segments as four signed points; each result on the result channel carries
// the intersection flag and the four orientation codes of the end points.
// Both channels use valid and ready, and a transfer happens on a clock edge
// where both are high. The tolerance register is written through cfg_wr_en
// and cfg_wr_data and should only change while no request is in flight.
// A request is taken every cycle while the receiver keeps result ready high. The
// front register forms the coordinate differences at the accepting edge; the result
// then passes through the two-entry queue, the product stage and the sum stage, and
// the code register then presents it on the result channel.
// Synchronous reset empties the front register, the queue and the back
// pipeline, and clears the tolerance to zero, which makes the test exact.
// When the receiver holds ready low, the result stays stable, the back stages,
// the queue and the front register fill up, and request ready drops once they
// are all full; no request is lost and none is repeated.
module segment_intersection_test (
  input  logic                  clk,
  input  logic                  rst,
  sit_req_if.sink               request,
  sit_rsp_if.source             result,
  input  logic                  cfg_wr_en,
  input  logic [sit_pkg::TOL_BITS-1:0] cfg_wr_data
);
  import sit_pkg::*;

  tol_t      tolerance;
  logic      push_valid;
  logic      push_ready;
  diff_set_t push_data;
  logic      pop_valid;
  logic      pop_ready;
  diff_set_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (cfg_wr_en) begin
      tolerance <= cfg_wr_data;
    end
  end

  sit_front u_front (
    .clk        (clk),
    .rst        (rst),
    .request    (request),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sit_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sit_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tolerance (tolerance),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule

// ----- tb/sv/segment_intersection_test_test.sv -----
`timescale 1ns / 1ps

module segment_intersection_test_test;
  import sit_pkg::*;

  typedef struct packed {
    coord_t seg1_start_x;
    coord_t seg1_start_y;
    coord_t seg1_end_x;
    coord_t seg1_end_y;
    coord_t seg2_start_x;
    coord_t seg2_start_y;
    coord_t seg2_end_x;
    coord_t seg2_end_y;
  } seg_pair_t;

  typedef struct packed {
    logic  intersects;
    code_t orient_seg2_start;
    code_t orient_seg2_end;
    code_t orient_seg1_start;
    code_t orient_seg1_end;
  } verdict_t;

  localparam int QUIET_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  tol_t cfg_wr_data;

  sit_req_if req_ch ();
  sit_rsp_if rsp_ch ();

  segment_intersection_test DUT (
    .clk         (clk),
    .rst         (rst),
    .request     (req_ch),
    .result      (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  seg_pair_t pending_pairs[$];
  verdict_t  expected_verdicts[$];
  seg_pair_t next_pair;
  tol_t      tolerance_now = '0;
  logic      request_taken = 1'b0;
  int        req_idle_pct = 35;
  int        rsp_idle_pct = 35;
  int        hold_cycles = 0;
  int        requests_taken = 0;
  int        results_checked = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        tolerance_settings = 1;
  int        hits_seen = 0;
  int        collinear_codes_seen = 0;

  always #4 clk = ~clk;

  function automatic code_t orientation(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                        coord_t px, coord_t py, tol_t tol);
    longint dx, dy, qx, qy, cr, margin;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    qx = longint'(px) - longint'(sx);
    qy = longint'(py) - longint'(sy);
    margin = longint'(tol);
    cr = dx * qy - dy * qx;
    if (cr > margin) return ORIENT_CCW;
    if (cr < -margin) return ORIENT_CW;
    if (dx * qx + dy * qy < -margin) return ORIENT_BEHIND;
    if (qx * qx + qy * qy > dx * dx + dy * dy + margin) return ORIENT_BEYOND;
    return ORIENT_ON;
  endfunction

  function automatic verdict_t predict_verdict(seg_pair_t p, tol_t tol);
    verdict_t v;
    v.orient_seg2_start = orientation(p.seg1_start_x, p.seg1_start_y, p.seg1_end_x,
                                      p.seg1_end_y, p.seg2_start_x, p.seg2_start_y, tol);
    v.orient_seg2_end   = orientation(p.seg1_start_x, p.seg1_start_y, p.seg1_end_x,
                                      p.seg1_end_y, p.seg2_end_x, p.seg2_end_y, tol);
    v.orient_seg1_start = orientation(p.seg2_start_x, p.seg2_start_y, p.seg2_end_x,
                                      p.seg2_end_y, p.seg1_start_x, p.seg1_start_y, tol);
    v.orient_seg1_end   = orientation(p.seg2_start_x, p.seg2_start_y, p.seg2_end_x,
                                      p.seg2_end_y, p.seg1_end_x, p.seg1_end_y, tol);
    v.intersects = (int'(v.orient_seg2_start) * int'(v.orient_seg2_end) <= 0) &&
                   (int'(v.orient_seg1_start) * int'(v.orient_seg1_end) <= 0);
    return v;
  endfunction

  function automatic seg_pair_t pair_of(int ax, int ay, int bx, int by,
                                        int cx, int cy, int dx, int dy);
    seg_pair_t p;
    p.seg1_start_x = coord_t'(ax);
    p.seg1_start_y = coord_t'(ay);
    p.seg1_end_x   = coord_t'(bx);
    p.seg1_end_y   = coord_t'(by);
    p.seg2_start_x = coord_t'(cx);
    p.seg2_start_y = coord_t'(cy);
    p.seg2_end_x   = coord_t'(dx);
    p.seg2_end_y   = coord_t'(dy);
    return p;
  endfunction

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return pick(-32768, 32767);
    endcase
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int mode, bx, by, ux, uy, span, jit;
    int k[4];
    mode = $urandom_range(99);
    if (mode < 25) begin
      p = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
    end else if (mode < 45) begin
      p = pair_of(pick(-16, 16), pick(-16, 16), pick(-16, 16), pick(-16, 16),
                  pick(-16, 16), pick(-16, 16), pick(-16, 16), pick(-16, 16));
    end else if (mode < 80) begin
      // Points on one line, exactly for the short span, with small jitter for the long one.
      if (mode < 65) begin
        span = 4;
        jit = 0;
        bx = pick(-1000, 1000);
        by = pick(-1000, 1000);
      end else begin
        span = 2000;
        jit = 2;
        bx = pick(-16000, 16000);
        by = pick(-16000, 16000);
      end
      ux = pick(-span, span);
      uy = pick(-span, span);
      foreach (k[i]) k[i] = pick(-4, 4);
      p = pair_of(bx + k[0] * ux + pick(-jit, jit), by + k[0] * uy + pick(-jit, jit),
                  bx + k[1] * ux + pick(-jit, jit), by + k[1] * uy + pick(-jit, jit),
                  bx + k[2] * ux + pick(-jit, jit), by + k[2] * uy + pick(-jit, jit),
                  bx + k[3] * ux + pick(-jit, jit), by + k[3] * uy + pick(-jit, jit));
    end else if (mode < 90) begin
      p = pair_of(pick(-100, 100), pick(-100, 100), pick(-100, 100), pick(-100, 100),
                  pick(-100, 100), pick(-100, 100), pick(-100, 100), pick(-100, 100));
      if ($urandom_range(1)) begin
        p.seg2_start_x = p.seg1_end_x;
        p.seg2_start_y = p.seg1_end_y;
      end else begin
        p.seg2_end_x = p.seg1_start_x;
        p.seg2_end_y = p.seg1_start_y;
      end
    end else begin
      p = pair_of(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                  extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("MISMATCH result %0d: %s got %0d, expected %0d", results_checked, what, got,
             want);
  endtask

  task automatic write_tolerance(tol_t value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tolerance_now = value;
    tolerance_settings++;
  endtask

  task automatic wait_idle();
    while (pending_pairs.size() != 0 || req_ch.valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || request_taken) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
        next_pair = pending_pairs.pop_front();
        req_ch.seg1_start_x <= next_pair.seg1_start_x;
        req_ch.seg1_start_y <= next_pair.seg1_start_y;
        req_ch.seg1_end_x   <= next_pair.seg1_end_x;
        req_ch.seg1_end_y   <= next_pair.seg1_end_y;
        req_ch.seg2_start_x <= next_pair.seg2_start_x;
        req_ch.seg2_start_y <= next_pair.seg2_start_y;
        req_ch.seg2_end_x   <= next_pair.seg2_end_x;
        req_ch.seg2_end_y   <= next_pair.seg2_end_y;
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  always @(posedge clk) begin
    verdict_t got, want;
    logic req_fire, rsp_fire;
    req_fire = !rst && req_ch.valid && req_ch.ready;
    rsp_fire = !rst && rsp_ch.valid && rsp_ch.ready;
    request_taken <= req_fire;
    if (req_fire) begin
      expected_verdicts.push_back(predict_verdict(pair_of(
        req_ch.seg1_start_x, req_ch.seg1_start_y, req_ch.seg1_end_x, req_ch.seg1_end_y,
        req_ch.seg2_start_x, req_ch.seg2_start_y, req_ch.seg2_end_x, req_ch.seg2_end_y),
        tolerance_now));
      requests_taken++;
    end
    if (rsp_fire) begin
      got.intersects        = rsp_ch.intersects;
      got.orient_seg2_start = rsp_ch.orient_seg2_start;
      got.orient_seg2_end   = rsp_ch.orient_seg2_end;
      got.orient_seg1_start = rsp_ch.orient_seg1_start;
      got.orient_seg1_end   = rsp_ch.orient_seg1_end;
      if (expected_verdicts.size() == 0) begin
        report_mismatch("result with no request pending, intersects", got.intersects, 0);
      end else begin
        want = expected_verdicts.pop_front();
        if (got.intersects !== want.intersects)
          report_mismatch("intersects", got.intersects, want.intersects);
        if (got.orient_seg2_start !== want.orient_seg2_start)
          report_mismatch("orient_seg2_start", got.orient_seg2_start, want.orient_seg2_start);
        if (got.orient_seg2_end !== want.orient_seg2_end)
          report_mismatch("orient_seg2_end", got.orient_seg2_end, want.orient_seg2_end);
        if (got.orient_seg1_start !== want.orient_seg1_start)
          report_mismatch("orient_seg1_start", got.orient_seg1_start, want.orient_seg1_start);
        if (got.orient_seg1_end !== want.orient_seg1_end)
          report_mismatch("orient_seg1_end", got.orient_seg1_end, want.orient_seg1_end);
        if (want.intersects) hits_seen++;
        if (want.orient_seg2_start == ORIENT_BEHIND || want.orient_seg2_start == ORIENT_BEYOND ||
            want.orient_seg2_start == ORIENT_ON)
          collinear_codes_seen++;
      end
      results_checked++;
    end
    if (req_fire || rsp_fire || rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout after %0d cycles with no transfer", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int mark;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.seg1_start_x = '0;
    req_ch.seg1_start_y = '0;
    req_ch.seg1_end_x = '0;
    req_ch.seg1_end_y = '0;
    req_ch.seg2_start_x = '0;
    req_ch.seg2_start_y = '0;
    req_ch.seg2_end_x = '0;
    req_ch.seg2_end_y = '0;
    rsp_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The exact test with the reset tolerance: extremes, collinear cases, degenerate segments.
    pending_pairs.push_back(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    pending_pairs.push_back(pair_of(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    pending_pairs.push_back(pair_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                                    -32768));
    pending_pairs.push_back(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    pending_pairs.push_back(pair_of(-32768, 0, 32767, 0, 0, 0, 32767, 0));
    pending_pairs.push_back(pair_of(-32768, 32767, 32767, 32767, -32768, -32768, 32767, -32768));
    pending_pairs.push_back(pair_of(0, 0, 10, 0, -5, 0, -1, 0));
    pending_pairs.push_back(pair_of(0, 0, 10, 0, 5, 0, 15, 0));
    pending_pairs.push_back(pair_of(0, 0, 10, 0, 10, 0, 20, 0));
    pending_pairs.push_back(pair_of(10, 0, 0, 0, -5, 0, 20, 0));
    pending_pairs.push_back(pair_of(0, 0, 10, 0, 0, 1, 10, 1));
    pending_pairs.push_back(pair_of(0, 0, 10, 0, 5, 0, 5, 5));
    pending_pairs.push_back(pair_of(0, 0, 4, 4, 0, 4, 4, 0));
    pending_pairs.push_back(pair_of(0, 0, 1, 1, 5, 0, 4, 1));
    pending_pairs.push_back(pair_of(3, 3, 3, 3, 0, 0, 6, 6));
    pending_pairs.push_back(pair_of(3, 4, 3, 4, 0, 0, 6, 6));
    pending_pairs.push_back(pair_of(1, 1, 1, 1, 2, 2, 2, 2));
    pending_pairs.push_back(pair_of(-1, -1, -1, -1, -1, -1, -1, -1));
    repeat (150) pending_pairs.push_back(random_pair());
    wait_idle();

    // Widest tolerance: slightly bent lines and near misses count as collinear.
    write_tolerance(16'hFFFF);
    pending_pairs.push_back(pair_of(0, 0, 100, 0, 50, 1, 60, 1));
    pending_pairs.push_back(pair_of(0, 0, 100, 0, -3, 0, -1, 0));
    pending_pairs.push_back(pair_of(0, 0, 100, 0, 101, 0, 200, 0));
    pending_pairs.push_back(pair_of(0, 0, 1000, 0, 0, 70, 1000, 70));
    pending_pairs.push_back(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    repeat (100) pending_pairs.push_back(random_pair());
    wait_idle();

    // A middle tolerance with both sides running flat out.
    write_tolerance(tol_t'($urandom_range(1, 65534)));
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    repeat (100) pending_pairs.push_back(random_pair());
    wait_idle();

    // Back to the exact test, with a long receiver stall while requests keep coming.
    write_tolerance('0);
    req_idle_pct = 35;
    rsp_idle_pct = 35;
    mark = requests_taken + 20;
    repeat (150) pending_pairs.push_back(random_pair());
    while (requests_taken < mark) @(posedge clk);
    hold_cycles = 80;
    wait_idle();

    $display("Checked %0d results from %0d segment pairs under %0d tolerance settings.",
             results_checked, requests_taken, tolerance_settings);
    $display("Intersections expected: %0d; collinear codes for the second start point: %0d.",
             hits_seen, collinear_codes_seen);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
